[hdl/htsc_pkg.sv]
// Shared types, constants and heading helpers for the heading turn speed controller.
package htsc_pkg;

  localparam int DegW   = 9;
  localparam int AbsW   = 8;
  localparam int GainW  = 16;
  localparam int SpeedW = 9;
  localparam int WinW   = 8;
  localparam int RateW  = 10;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam int ProdW    = GainW + AbsW;
  localparam int DivRadix = 2;
  localparam int DivIters = ProdW / DivRadix;
  localparam int DivCntW  = $clog2(DivIters);

  localparam logic [DegW-1:0] DegFull = 9'd360;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgGain       = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMinSpeed   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxSpeed   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgNearWindow = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDoneWindow = 3'd4;

  localparam logic [GainW-1:0]  GainRst       = 16'd256;
  localparam logic [SpeedW-1:0] MinSpeedRst   = 9'd51;
  localparam logic [SpeedW-1:0] MaxSpeedRst   = 9'd256;
  localparam logic [WinW-1:0]   NearWindowRst = 8'd10;
  localparam logic [WinW-1:0]   DoneWindowRst = 8'd1;

  typedef struct packed {
    logic load_in;   // capture an input word
    logic prep;      // errors, done flag, start latch
    logic mul;       // form gain * |current error|, clear divider
    logic div_step;  // one divider iteration
    logic fin_load;  // clamp and load the result register
  } htsc_cmd_t;

  typedef struct packed {
    logic div_last;
  } htsc_status_t;

  function automatic logic [DegW-1:0] wrap_deg(input logic [DegW-1:0] d);
    return (d >= DegFull) ? d - DegFull : d;
  endfunction

  function automatic logic [DegW-1:0] snap_deg(input logic [DegW-1:0] d);
    logic [DegW-1:0] r;
    r = d;
    if (d >= 9'd88 && d <= 9'd92) r = 9'd90;
    else if (d >= 9'd178 && d <= 9'd182) r = 9'd180;
    else if (d >= 9'd268 && d <= 9'd272) r = 9'd270;
    else if (d >= 9'd358 || d <= 9'd2) r = 9'd0;
    return r;
  endfunction

  // signed error t - s folded into -180..179
  function automatic logic signed [DegW-1:0] wrap_err(input logic [DegW-1:0] t,
                                                     input logic [DegW-1:0] s);
    logic signed [DegW:0] diff;
    diff = $signed({1'b0, t}) - $signed({1'b0, s});
    if (diff >= 10'sd180) diff = diff - 10'sd360;
    else if (diff < -10'sd180) diff = diff + 10'sd360;
    return diff[DegW-1:0];
  endfunction

  function automatic logic [AbsW-1:0] abs_err(input logic signed [DegW-1:0] e);
    logic signed [DegW-1:0] m;
    m = e[DegW-1] ? -e : e;
    return m[AbsW-1:0];
  endfunction

endpackage

[hdl/htsc_datapath.sv]
// Datapath: configuration registers, heading errors, start latch, radix-4 divider, result.
module htsc_datapath import htsc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_wdata_i,
  input  logic [DegW-1:0]            target_deg_i,
  input  logic [DegW-1:0]            current_deg_i,
  input  logic                       snap_enable_i,
  input  htsc_cmd_t                  cmd_i,
  output htsc_status_t               status_o,
  output logic signed [RateW-1:0]    turn_rate_o,
  output logic                       done_res_o
);

  logic [GainW-1:0]  gain_q;
  logic [SpeedW-1:0] min_speed_q, max_speed_q;
  logic [WinW-1:0]   near_window_q, done_window_q;

  logic [DegW-1:0] tgt_q, cur_q;
  logic            start_valid_q, start_valid_d;
  logic [DegW-1:0] start_heading_q, start_heading_d;
  logic [AbsW-1:0] aes_q, aec_q, aes_d, aec_d;
  logic            cw_q, cw_d, done_q, done_d;
  logic [ProdW-1:0] quo_q, quo_d;
  logic [AbsW-1:0]  rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q;
  logic signed [RateW-1:0] rate_q, rate_d;
  logic            done_out_q;
  logic [DegW-1:0] tgt_in;
  logic [SpeedW-1:0] speed;

  // config writes; out-of-range indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q        <= GainRst;
      min_speed_q   <= MinSpeedRst;
      max_speed_q   <= MaxSpeedRst;
      near_window_q <= NearWindowRst;
      done_window_q <= DoneWindowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgGain:       gain_q        <= cfg_wdata_i[GainW-1:0];
        CfgMinSpeed:   min_speed_q   <= cfg_wdata_i[SpeedW-1:0];
        CfgMaxSpeed:   max_speed_q   <= cfg_wdata_i[SpeedW-1:0];
        CfgNearWindow: near_window_q <= cfg_wdata_i[WinW-1:0];
        CfgDoneWindow: done_window_q <= cfg_wdata_i[WinW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tgt_in = wrap_deg(target_deg_i);
    if (snap_enable_i) tgt_in = snap_deg(tgt_in);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      tgt_q <= tgt_in;
      cur_q <= wrap_deg(current_deg_i);
    end
  end

  // errors and done rule against the latched start heading
  always_comb begin
    logic [DegW-1:0]        start_eff;
    logic signed [DegW-1:0] es, ec;
    logic                   passed;
    start_eff = start_valid_q ? start_heading_q : cur_q;
    es = wrap_err(tgt_q, start_eff);
    ec = wrap_err(tgt_q, cur_q);
    cw_d  = ~es[DegW-1];
    aes_d = abs_err(es);
    aec_d = abs_err(ec);
    passed = cw_d ? (cur_q >= tgt_q) : (cur_q <= tgt_q);
    done_d = (aec_d < near_window_q) && (passed || (aec_d < done_window_q));
    start_heading_d = start_eff;
    start_valid_d   = ~done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_valid_q   <= 1'b0;
      start_heading_q <= '0;
    end else if (cmd_i.prep) begin
      start_valid_q   <= start_valid_d;
      start_heading_q <= start_heading_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      aes_q  <= aes_d;
      aec_q  <= aec_d;
      cw_q   <= cw_d;
      done_q <= done_d;
    end
  end

  // two restoring steps per cycle
  always_comb begin
    logic [AbsW:0] t;
    logic [AbsW-1:0] r;
    logic [ProdW-1:0] q;
    r = rem_q;
    q = quo_q;
    for (int i = 0; i < DivRadix; i++) begin
      t = {r, q[ProdW-1]};
      q = {q[ProdW-2:0], 1'b0};
      if (t >= {1'b0, aes_q}) begin
        t = t - {1'b0, aes_q};
        q[0] = 1'b1;
      end
      r = t[AbsW-1:0];
    end
    rem_d = r;
    quo_d = q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      quo_q <= ProdW'(gain_q) * ProdW'(aec_q);
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign status_o.div_last = (cnt_q == DivCntW'(DivIters - 1));

  // clamp low then high, so max_speed wins
  always_comb begin
    logic [ProdW-1:0] s1, s2;
    s1 = (quo_q < ProdW'(min_speed_q)) ? ProdW'(min_speed_q) : quo_q;
    s2 = (s1 > ProdW'(max_speed_q)) ? ProdW'(max_speed_q) : s1;
    speed = (aes_q == '0) ? max_speed_q : s2[SpeedW-1:0];
    if (done_q) rate_d = '0;
    else if (cw_q) rate_d = -$signed({1'b0, speed});
    else rate_d = $signed({1'b0, speed});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_load) begin
      rate_q     <= rate_d;
      done_out_q <= done_q;
    end
  end

  assign turn_rate_o = rate_q;
  assign done_res_o  = done_out_q;

endmodule

[hdl/htsc_ctrl.sv]
// Controller: sequences capture, prep, multiply, divide and result load.
module htsc_ctrl import htsc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  htsc_status_t status_i,
  output htsc_cmd_t    cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = StPrep;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = StFin;
      end
      StFin: begin
        // hold until the result register is free
        if (slot_free) begin
          cmd_o.fin_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.fin_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while a word waits");

  a_accept_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StPrep))
    else $error("accepted word did not advance to prep");

  a_div_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && status_i.div_last) |=> (state_q == StFin))
    else $error("divider end did not advance to result load");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin_load |=> out_valid_q)
    else $error("result load did not raise out_valid");

endmodule

[hdl/heading_turn_speed_controller_core.sv]
// Top level of the heading turn speed controller: controller plus datapath.
// A result word passes through capture, prep, multiply, the radix-4 divider of
// gain * |current error| by |start error| and the result load; a new input word
// is taken only after the previous word has been loaded into the result register.
// A new input word is taken while the previous result still waits at the output.
// Reset (rst_ni low, asynchronous) clears the turn latch, the handshake state and
// restores the configuration registers to their defaults.
module heading_turn_speed_controller_core import htsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [DegW-1:0]         target_deg_i,
  input  logic [DegW-1:0]         current_deg_i,
  input  logic                    snap_enable_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [RateW-1:0] turn_rate_o,
  output logic                    done_res_o
);

  htsc_cmd_t    cmd;
  htsc_status_t status;

  htsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  htsc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .target_deg_i  (target_deg_i),
    .current_deg_i (current_deg_i),
    .snap_enable_i (snap_enable_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .turn_rate_o   (turn_rate_o),
    .done_res_o    (done_res_o)
  );

endmodule

[bench/turn_rate_checker.sv]
// Checker for the heading turn speed controller: predicts each turn rate word and compares.
module turn_rate_checker import htsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [DegW-1:0]         target_deg_i,
  input  logic [DegW-1:0]         current_deg_i,
  input  logic                    snap_enable_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [RateW-1:0] turn_rate_i,
  input  logic                    done_res_i,
  output int                      mismatches_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [RateW-1:0] rate;
    logic                    done;
  } turn_word_t;

  logic [GainW-1:0]  gain_q;
  logic [SpeedW-1:0] min_speed_q;
  logic [SpeedW-1:0] max_speed_q;
  logic [WinW-1:0]   near_win_q;
  logic [WinW-1:0]   done_win_q;
  logic              turn_open;
  logic [DegW-1:0]   turn_start;
  turn_word_t        rate_expect_q[$];

  function automatic int unsigned fold_deg(input logic [DegW-1:0] d);
    int unsigned v;
    v = d;
    return (v >= 360) ? v - 360 : v;
  endfunction

  function automatic int unsigned snap_right_angle(input int unsigned d);
    if (d >= 88 && d <= 92) return 90;
    if (d >= 178 && d <= 182) return 180;
    if (d >= 268 && d <= 272) return 270;
    if (d >= 358 || d <= 2) return 0;
    return d;
  endfunction

  // signed heading difference t - s folded into -180..179
  function automatic int heading_offset(input int unsigned t, input int unsigned s);
    return ((int'(t) - int'(s) + 540) % 360) - 180;
  endfunction

  function automatic turn_word_t predict_turn(input logic [DegW-1:0] tgt_raw,
                                              input logic [DegW-1:0] cur_raw,
                                              input logic            snap);
    int unsigned tgt, cur, mag_s, mag_c, spd;
    int          err_s, err_c, rv;
    logic        cw, fin;
    turn_word_t  res;
    tgt = fold_deg(tgt_raw);
    cur = fold_deg(cur_raw);
    if (snap) tgt = snap_right_angle(tgt);
    // latch the start heading on the first tick of a turn
    if (!turn_open) begin
      turn_start = cur[DegW-1:0];
      turn_open  = 1'b1;
    end
    err_s = heading_offset(tgt, turn_start);
    err_c = heading_offset(tgt, cur);
    cw    = (err_s >= 0);
    mag_s = (err_s < 0) ? -err_s : err_s;
    mag_c = (err_c < 0) ? -err_c : err_c;
    if (mag_s == 0) begin
      spd = max_speed_q;
    end else begin
      spd = (gain_q * mag_c) / mag_s;
      // lower clamp first so max wins when the bounds cross
      if (spd < min_speed_q) spd = min_speed_q;
      if (spd > max_speed_q) spd = max_speed_q;
    end
    fin = 1'b0;
    if (mag_c < near_win_q) begin
      if (cw ? (cur >= tgt) : (cur <= tgt)) fin = 1'b1;
      if (!fin && mag_c < done_win_q) fin = 1'b1;
    end
    if (fin) turn_open = 1'b0;
    rv = fin ? 0 : (cw ? -int'(spd) : int'(spd));
    res.rate = rv[RateW-1:0];
    res.done = fin;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    turn_word_t got, want;
    if (!rst_ni) begin
      gain_q       = GainRst;
      min_speed_q  = MinSpeedRst;
      max_speed_q  = MaxSpeedRst;
      near_win_q   = NearWindowRst;
      done_win_q   = DoneWindowRst;
      turn_open    = 1'b0;
      turn_start   = '0;
      mismatches_o = 0;
      rate_expect_q.delete();
    end else begin
      // check the output word before queuing a new prediction
      if (out_valid_i && out_ready_i) begin
        got.rate = turn_rate_i;
        got.done = done_res_i;
        if (rate_expect_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t ns: result word with nothing expected: rate %0d done %0b",
                     $time, $signed(got.rate), got.done);
          mismatches_o++;
        end else begin
          want = rate_expect_q.pop_front();
          if (got.rate !== want.rate || got.done !== want.done) begin
            if (mismatches_o < 10)
              $display("%0t ns: mismatch: expected rate %0d done %0b, got rate %0d done %0b",
                       $time, $signed(want.rate), want.done, $signed(got.rate), got.done);
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgGain:       gain_q      = cfg_wdata_i[GainW-1:0];
          CfgMinSpeed:   min_speed_q = cfg_wdata_i[SpeedW-1:0];
          CfgMaxSpeed:   max_speed_q = cfg_wdata_i[SpeedW-1:0];
          CfgNearWindow: near_win_q  = cfg_wdata_i[WinW-1:0];
          CfgDoneWindow: done_win_q  = cfg_wdata_i[WinW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        rate_expect_q.push_back(predict_turn(target_deg_i, current_deg_i, snap_enable_i));
    end
    pending_o = rate_expect_q.size();
  end

endmodule

[bench/heading_turn_speed_controller_core_test.sv]
// Testbench top for the heading turn speed controller: stimulus, register setup and verdict.
module heading_turn_speed_controller_core_test;
  import htsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles    = 150;
  localparam int WatchdogLimit = 2000;
  localparam int EndSettle     = 40;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CfgIdxW-1:0]      cfg_index;
  logic [CfgDataW-1:0]     cfg_wdata;
  logic                    in_valid;
  logic                    in_ready;
  logic [DegW-1:0]         target_deg;
  logic [DegW-1:0]         current_deg;
  logic                    snap_enable;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [RateW-1:0] turn_rate;
  logic                    done_res;

  int          mismatches;
  int          pending;
  int          quiet_cycles = 0;
  int unsigned tick_count = 0;
  bit          calm = 1'b0;
  bit          hold_out = 1'b0;

  heading_turn_speed_controller_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .target_deg_i (target_deg),
    .current_deg_i(current_deg),
    .snap_enable_i(snap_enable),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .turn_rate_o  (turn_rate),
    .done_res_o   (done_res)
  );

  turn_rate_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .target_deg_i (target_deg),
    .current_deg_i(current_deg),
    .snap_enable_i(snap_enable),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .turn_rate_i  (turn_rate),
    .done_res_i   (done_res),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  // offer one tick word after a random gap, hold it until taken
  task automatic send_tick(input int unsigned t, input int unsigned c, input bit s);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    target_deg  <= t[DegW-1:0];
    current_deg <= c[DegW-1:0];
    snap_enable <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    tick_count++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [CfgDataW-1:0] g, input logic [CfgDataW-1:0] mn,
                               input logic [CfgDataW-1:0] mx, input logic [CfgDataW-1:0] nw,
                               input logic [CfgDataW-1:0] dw);
    write_reg(CfgGain, g);
    write_reg(CfgMinSpeed, mn);
    write_reg(CfgMaxSpeed, mx);
    write_reg(CfgNearWindow, nw);
    write_reg(CfgDoneWindow, dw);
    // an unused index must leave every register alone
    write_reg(CfgIdxW'($urandom_range(int'(CfgDoneWindow) + 1, (1 << CfgIdxW) - 1)),
              CfgDataW'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_settings();
    load_settings(CfgDataW'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1024)),
                  CfgDataW'($urandom_range(0, 256)), CfgDataW'($urandom_range(0, 256)),
                  CfgDataW'($urandom_range(0, 180)), CfgDataW'($urandom_range(0, 180)));
  endtask

  // drop valid and wait until every result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // headings below 152 may also arrive with 360 added
  function automatic int unsigned alias_deg(input int unsigned d);
    return (d <= 151 && $urandom_range(0, 7) == 0) ? d + 360 : d;
  endfunction

  // one turn: headings step from the start toward the target, with some noise words
  task automatic run_turn();
    int unsigned start, tgt, cur, step, n;
    int          err;
    bit          snap;
    start = $urandom_range(0, 359);
    snap  = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0)
      tgt = ($urandom_range(0, 3) * 90 + 357 + $urandom_range(0, 6)) % 360;
    else
      tgt = $urandom_range(0, 359);
    if ($urandom_range(0, 7) == 0) tgt = start;
    err = ((int'(tgt) - int'(start) + 540) % 360) - 180;
    n   = $urandom_range(1, 12);
    cur = start;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_tick($urandom_range(0, 511), $urandom_range(0, 511), 1'($urandom_range(0, 1)));
      else
        send_tick(alias_deg(tgt), alias_deg(cur), snap);
      step = $urandom_range(0, 40);
      cur  = (err >= 0) ? (cur + step) % 360 : (cur + 360 - step) % 360;
    end
    if ($urandom_range(0, 3) != 0) send_tick(alias_deg(tgt), alias_deg(tgt), snap);
  endtask

  task automatic run_phase(input int unsigned words);
    int unsigned goal;
    goal = tick_count + words;
    while (tick_count < goal) run_turn();
  endtask

  task automatic run_directed();
    // clockwise turn that ends on the target
    send_tick(90, 0, 0);
    send_tick(90, 45, 0);
    send_tick(90, 85, 0);
    send_tick(90, 90, 0);
    // counter-clockwise turn, held inside the near window short of the target
    send_tick(270, 0, 0);
    send_tick(270, 300, 0);
    send_tick(270, 275, 0);
    send_tick(270, 270, 0);
    // zero start error, heading extremes
    send_tick(45, 45, 0);
    send_tick(359, 0, 0);
    send_tick(0, 359, 0);
    // snap window edges
    send_tick(87, 200, 1);
    send_tick(88, 200, 1);
    send_tick(92, 200, 1);
    send_tick(93, 200, 1);
    send_tick(178, 0, 1);
    send_tick(182, 0, 1);
    send_tick(268, 0, 1);
    send_tick(272, 0, 1);
    send_tick(357, 100, 1);
    send_tick(358, 100, 1);
    send_tick(2, 100, 1);
    send_tick(3, 100, 1);
    // headings out of range
    send_tick(511, 360, 0);
    send_tick(360, 511, 1);
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CfgGain;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    target_deg  = '0;
    current_deg = '0;
    snap_enable = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    drain();

    load_settings(GainRst, CfgDataW'(MinSpeedRst), CfgDataW'(MaxSpeedRst),
                  CfgDataW'(NearWindowRst), CfgDataW'(DoneWindowRst));
    hold_out = 1'b1;
    run_phase(95);
    drain();

    load_settings(0, 0, 0, 0, 0);
    run_phase(45);
    drain();
    run_phase(45);
    drain();

    load_settings(1024, 0, 256, 0, 0);
    run_phase(80);
    drain();

    load_settings(16'hFFFF, 256, 256, 180, 180);
    run_phase(80);
    drain();

    // upper bits of the narrow registers are dropped
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(70);
    drain();

    load_settings(700, 200, 90, 30, 12);
    run_phase(80);
    drain();

    calm = 1'b1;
    load_random_settings();
    run_phase(80);
    drain();
    calm = 1'b0;

    repeat (3) begin
      load_random_settings();
      run_phase(60);
      drain();
    end

    repeat (EndSettle) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: random stalls per word, one long hold on request
  initial begin
    int unsigned stall;
    bit          held;
    held      = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_out && !held) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        held = 1'b1;
      end
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule

[heading_turn_speed_controller_core.f]
hdl/htsc_pkg.sv
hdl/htsc_datapath.sv
hdl/htsc_ctrl.sv
hdl/heading_turn_speed_controller_core.sv
bench/turn_rate_checker.sv
bench/heading_turn_speed_controller_core_test.sv
